// ----- rtl/core/plucked_string_synth_loop_unit_macros.svh -----
// Assertion helpers for the plucked string loop.
// PSL_ASSERT_IMP checks cons in the same cycle as ante.
// PSL_ASSERT_NXT checks cons in the cycle after ante.
`ifndef PLUCKED_STRING_SYNTH_LOOP_UNIT_MACROS_SVH
`define PLUCKED_STRING_SYNTH_LOOP_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PSL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("plucked string loop: same-cycle check failed");
`define PSL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("plucked string loop: next-cycle check failed");
`else
`define PSL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PSL_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/core/psl_pkg.sv -----
`timescale 1ns / 1ps

package psl_pkg;

	// default sizing
	localparam int PSL_DELAY_DEPTH = 4096;
	localparam int PSL_SAMPLE_BITS = 16;

	// register file geometry
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int WHOLE_W    = 12;
	localparam int FRAC_W     = 16;
	localparam int COEF_W     = 16;
	localparam int NOTE_W     = 24;
	localparam int POS_W      = 24;

	// reset values
	localparam logic [WHOLE_W-1:0] WHOLE_RST   = 12'd100;
	localparam logic [FRAC_W-1:0]  FRAC_RST    = 16'd0;
	localparam logic [COEF_W-1:0]  COEF_RST    = 16'd16384;
	localparam logic [COEF_W-1:0]  LOOP_RST    = 16'd32440;
	localparam logic [COEF_W-1:0]  SUSTAIN_RST = 16'd31000;
	localparam logic [NOTE_W-1:0]  NOTE_RST    = 24'd44100;

	localparam logic [COEF_W-1:0] Q15_ONE = 16'd32768;
	localparam logic [POS_W-1:0]  POS_MAX = 24'hFFFFFF;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PERIOD_WHOLE    = 3'd0,
		REG_PERIOD_FRACTION = 3'd1,
		REG_FILTER_COEF     = 3'd2,
		REG_HOLD_GAIN       = 3'd3,
		REG_TAIL_GAIN       = 3'd4,
		REG_NOTE_SAMPLES    = 3'd5
	} psl_reg_t;

	// Q1.15 coefficients above one saturate to one
	function automatic logic [COEF_W-1:0] clamp_q15(input logic [COEF_W-1:0] v);
		return (v > Q15_ONE) ? Q15_ONE : v;
	endfunction

endpackage

// ----- rtl/core/psl_if.sv -----
`timescale 1ns / 1ps

// excitation tick channel
interface psl_pluck_if import psl_pkg::*; #(
	parameter int SAMPLE_BITS = PSL_SAMPLE_BITS
) ();
	logic                          valid;
	logic                          ready;
	logic                          start_req;
	logic signed [SAMPLE_BITS-1:0] excitation;

	modport source (output valid, output start_req, output excitation, input ready);
	modport sink   (input valid, input start_req, input excitation, output ready);
endinterface

// synthesized sample channel
interface psl_audio_if import psl_pkg::*; #(
	parameter int SAMPLE_BITS = PSL_SAMPLE_BITS
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

// ----- rtl/core/plucked_string_synth_loop_unit.sv -----
`timescale 1ns / 1ps
// Channel   Role     Payload                        Transfer
// pluck     sink     start_req, excitation          valid && ready
// audio     source   sample                         valid && ready
// cfg       write    cfg_idx, cfg_data              cfg_we
//
// A tick goes straight to the result while the string loop is not yet closed (position
// below the period); once feedback is active it runs a two-pass modulo of the tap
// distance, two delay-line reads and five products, all on one shared multiplier.
// A pending result blocks the write-back until audio takes it; pluck is ready only
// when the sequencer is idle. Reset clears control state and restores the
// configuration defaults; the delay line itself is not cleared.
`include "plucked_string_synth_loop_unit_macros.svh"

module plucked_string_synth_loop_unit import psl_pkg::*; #(
	parameter int DELAY_DEPTH = PSL_DELAY_DEPTH,
	parameter int SAMPLE_BITS = PSL_SAMPLE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	psl_pluck_if.sink             pluck,
	psl_audio_if.source           audio
);

	localparam int AWD    = $clog2(DELAY_DEPTH);
	localparam int BACK_W = WHOLE_W + 1;
	localparam int RSH    = BACK_W + FRAC_W;
	localparam int AW     = ((SAMPLE_BITS > COEF_W) ? SAMPLE_BITS : COEF_W) + 1;
	localparam int BW     = RSH - 1;
	localparam int PW     = AW + BW;
	localparam int CW     = ((AWD > BACK_W) ? AWD : BACK_W) + 2;
	localparam int WT_W   = FRAC_W + 1;
	// exact quotient for any BACK_W-bit distance and depth up to 2^FRAC_W
	localparam longint RECIP = ((longint'(1) << RSH) + DELAY_DEPTH - 1) / DELAY_DEPTH;
	localparam longint SMAX  = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
	localparam longint SMIN  = -SMAX - 1;
	localparam logic signed [PW-1:0] HALF_16 = PW'(32768);
	localparam logic signed [PW-1:0] HALF_15 = PW'(16384);
	localparam logic [WT_W-1:0] WT_ONE = WT_W'(65536);

	typedef enum logic [3:0] {
		S_IDLE, S_MODQ, S_MODR, S_ADDR, S_RDF, S_RDN, S_MULN, S_MREF, S_MULG, S_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [WHOLE_W-1:0] whole_q;
	logic [FRAC_W-1:0]  frac_q;
	logic [COEF_W-1:0]  coef_q;
	logic [COEF_W-1:0]  hold_gain_q;
	logic [COEF_W-1:0]  sustain_q;
	logic [NOTE_W-1:0]  note_q;

	// loop state
	logic [POS_W-1:0]              pos_q;
	logic [AWD-1:0]                wr_q;
	logic signed [SAMPLE_BITS-1:0] prev_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;

	// per-tick working registers
	logic                          gsel_q;
	logic [BACK_W-1:0]             back_q;
	logic [BACK_W-1:0]             quot_q;
	logic [BACK_W-1:0]             rem_q;
	logic [AWD-1:0]                far_q;
	logic [COEF_W-1:0]             ga_q;
	logic signed [PW-1:0]          ip_q;
	logic signed [PW-1:0]          sum_q;
	logic signed [SAMPLE_BITS-1:0] ref_q;

	logic signed [SAMPLE_BITS-1:0] rd_data;
	logic                          rd_en;
	logic [AWD-1:0]                rd_addr;
	logic                          in_xfer;
	logic                          res_load;
	logic [POS_W-1:0]              pos_eff;
	logic                          fb_on;
	logic [COEF_W-1:0]             a_c;
	logic [COEF_W-1:0]             g_c;
	logic [WT_W-1:0]               w_far;
	logic [WT_W-1:0]               w_near;
	logic [AWD-1:0]                near_addr;
	logic [CW-1:0]                 far_w;
	logic [CW-1:0]                 far_fix;
	logic signed [AW-1:0]          mul_a;
	logic signed [BW-1:0]          mul_b;
	logic signed [PW-1:0]          prod;
	logic signed [PW-1:0]          ref_w;
	logic signed [PW-1:0]          ga_w;
	logic signed [PW-1:0]          rs_w;
	logic signed [SAMPLE_BITS-1:0] res_w;

	assign in_xfer     = pluck.valid && pluck.ready;
	assign res_load    = (state_q == S_DONE) && (!out_valid_q || audio.ready);
	assign pluck.ready = (state_q == S_IDLE);
	assign audio.valid = out_valid_q;
	assign audio.sample = sample_q;

	// note position and loop-closed test
	assign pos_eff = pluck.start_req ? '0 : pos_q;
	assign fb_on   = (pos_eff > POS_W'(whole_q)) ||
		((pos_eff == POS_W'(whole_q)) && (frac_q == '0));

	// coefficients and interpolation weights
	assign a_c    = clamp_q15(coef_q);
	assign g_c    = clamp_q15(gsel_q ? hold_gain_q : sustain_q);
	assign w_far  = (frac_q == '0) ? WT_ONE : WT_W'(frac_q);
	assign w_near = (frac_q == '0) ? '0 : WT_ONE - WT_W'(frac_q);

	// tap addresses
	assign far_w     = CW'(wr_q) + CW'(DELAY_DEPTH) - CW'(rem_q);
	assign far_fix   = (far_w >= CW'(DELAY_DEPTH)) ? far_w - CW'(DELAY_DEPTH) : far_w;
	assign near_addr = (far_q == AWD'(DELAY_DEPTH - 1)) ? '0 : far_q + 1'b1;

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MODQ: begin
				mul_a = AW'(back_q);
				mul_b = BW'(RECIP);
			end
			S_MODR: begin
				mul_a = AW'(quot_q);
				mul_b = BW'(DELAY_DEPTH);
			end
			S_ADDR: begin
				mul_a = AW'(g_c);
				mul_b = BW'(a_c);
			end
			S_RDF: begin
				mul_a = AW'(prev_q);
				mul_b = BW'(Q15_ONE - a_c);
			end
			S_RDN: begin
				mul_a = AW'(rd_data);
				mul_b = BW'(w_far);
			end
			S_MULN: begin
				mul_a = AW'(rd_data);
				mul_b = BW'(w_near);
			end
			S_MULG: begin
				mul_a = AW'(ref_q);
				mul_b = BW'(ga_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// rounding (half up) and output saturation
	assign ref_w = (ip_q + HALF_16) >>> 16;
	assign ga_w  = (prod + HALF_15) >>> 15;
	assign rs_w  = (sum_q + HALF_15) >>> 15;
	assign res_w = (rs_w > PW'(SMAX)) ? SAMPLE_BITS'(SMAX) :
		(rs_w < PW'(SMIN)) ? SAMPLE_BITS'(SMIN) : rs_w[SAMPLE_BITS-1:0];

	// delay line read port
	assign rd_en   = (state_q == S_RDF) || (state_q == S_RDN);
	assign rd_addr = (state_q == S_RDN) ? near_addr : far_q;

	psl_delay_ram #(
		.DEPTH (DELAY_DEPTH),
		.WIDTH (SAMPLE_BITS)
	) u_delay (
		.clk     (clk),
		.wr_en   (res_load),
		.wr_addr (wr_q),
		.wr_data (res_w),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			whole_q     <= WHOLE_RST;
			frac_q      <= FRAC_RST;
			coef_q      <= COEF_RST;
			hold_gain_q <= LOOP_RST;
			sustain_q   <= SUSTAIN_RST;
			note_q      <= NOTE_RST;
		end else if (cfg_we) begin
			case (psl_reg_t'(cfg_idx))
				REG_PERIOD_WHOLE:    whole_q     <= cfg_data[WHOLE_W-1:0];
				REG_PERIOD_FRACTION: frac_q      <= cfg_data[FRAC_W-1:0];
				REG_FILTER_COEF:     coef_q      <= cfg_data[COEF_W-1:0];
				REG_HOLD_GAIN:       hold_gain_q <= cfg_data[COEF_W-1:0];
				REG_TAIL_GAIN:       sustain_q   <= cfg_data[COEF_W-1:0];
				REG_NOTE_SAMPLES:    note_q      <= cfg_data[NOTE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer, loop state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pos_q       <= '0;
			wr_q        <= '0;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result wins over the transfer of the old one
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (audio.valid && audio.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						pos_q   <= (pos_eff == POS_MAX) ? POS_MAX : pos_eff + 1'b1;
						state_q <= fb_on ? S_MODQ : S_DONE;
					end
				end
				S_MODQ: state_q <= S_MODR;
				S_MODR: state_q <= S_ADDR;
				S_ADDR: state_q <= S_RDF;
				S_RDF:  state_q <= S_RDN;
				S_RDN:  state_q <= S_MULN;
				S_MULN: state_q <= S_MREF;
				S_MREF: state_q <= S_MULG;
				S_MULG: state_q <= S_DONE;
				S_DONE: begin
					if (res_load) begin
						prev_q      <= res_w;
						wr_q        <= (wr_q == AWD'(DELAY_DEPTH - 1)) ? '0 : wr_q + 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				gsel_q <= (pos_eff < POS_W'(note_q));
				back_q <= (frac_q == '0) ? BACK_W'(whole_q) : BACK_W'(whole_q) + 1'b1;
				sum_q  <= PW'(pluck.excitation) <<< 15;
			end
			S_MODQ: quot_q <= prod[RSH+BACK_W-1:RSH];
			S_MODR: rem_q  <= back_q - prod[BACK_W-1:0];
			S_ADDR: begin
				far_q <= far_fix[AWD-1:0];
				ga_q  <= ga_w[COEF_W-1:0];
			end
			S_RDF:  sum_q  <= sum_q + prod;
			S_RDN:  ip_q   <= prod;
			S_MULN: ip_q   <= ip_q + prod;
			S_MREF: ref_q  <= ref_w[SAMPLE_BITS-1:0];
			S_MULG: sum_q  <= sum_q + prod;
			S_DONE: begin
				if (res_load) begin
					sample_q <= res_w;
				end
			end
			default: begin
			end
		endcase
	end

	// checks
	`PSL_ASSERT_NXT(a_busy_after_xfer, clk, arst_n, in_xfer, !pluck.ready)
	`PSL_ASSERT_NXT(a_load_shows_valid, clk, arst_n, res_load, audio.valid)
	`PSL_ASSERT_NXT(a_wr_advances, clk, arst_n, res_load, wr_q != $past(wr_q))
	`PSL_ASSERT_NXT(a_stall_holds_done, clk, arst_n,
		(state_q == S_DONE) && audio.valid && !audio.ready, state_q == S_DONE)
	`PSL_ASSERT_IMP(a_far_in_range, clk, arst_n, state_q == S_RDF,
		far_q <= AWD'(DELAY_DEPTH - 1))

endmodule

// ----- rtl/core/psl_delay_ram.sv -----
`timescale 1ns / 1ps

// single write port, single registered read port
module psl_delay_ram import psl_pkg::*; #(
	parameter int DEPTH = PSL_DELAY_DEPTH,
	parameter int WIDTH = PSL_SAMPLE_BITS
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
